// File: src/sphere_view_cull_assert.svh
// Assertion macros for the sphere view cull block.
// Used by the top level only; needs a clock named clk and a reset named rst in scope.
`ifndef SPHERE_VIEW_CULL_ASSERT_SVH
`define SPHERE_VIEW_CULL_ASSERT_SVH

// Same-cycle implication.
`define SVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/svc_pkg.sv
// Shared constants and widths for the sphere view cull pipeline.
// No dependencies.
package svc_pkg;

  localparam int OFFSET_LIMIT = 30000;
  localparam int FAR_LIMIT    = 17000;
  localparam int NEAR         = 150;
  localparam int SXW          = 160;
  localparam int SYW          = 120;

  localparam int D_W   = 16;  // world offset, range-checked to +/-30000
  localparam int P_W   = 32;  // matrix entry times offset
  localparam int V_W   = 22;  // rotated coordinate
  localparam int Z_W   = 17;  // divisor, valid only on live items
  localparam int A_W   = 38;  // |v| * distance
  localparam int B_W   = 31;  // radius * distance
  localparam int Q_W   = 32;  // quotient plus screen half-width
  localparam int T_W   = Q_W + Z_W;
  localparam int R_W   = 15;  // radius

  localparam logic [2:0] CFG_VIEW_X = 3'd0;
  localparam logic [2:0] CFG_VIEW_Y = 3'd1;
  localparam logic [2:0] CFG_VIEW_Z = 3'd2;
  localparam logic [2:0] CFG_ROW0   = 3'd3;
  localparam logic [2:0] CFG_ROW1   = 3'd4;
  localparam logic [2:0] CFG_ROW2   = 3'd5;
  localparam logic [2:0] CFG_PROJ   = 3'd6;

endpackage

// File: src/sphere_view_cull.sv
// Sphere view cull top level: configuration registers, pipeline and output stage.
// Depends on svc_pkg, svc_rotate, svc_project, svc_div and sphere_view_cull_assert.svh.

// One sphere is taken per clock unless the output stalls, and one visible flag
// leaves per sphere, in order, through offset and rotation, the near/far test and
// projection products, the pipelined radius divider (one quotient bit a stage),
// the screen-bound multiply and the output register. The whole pipeline moves on
// a single advance signal, so a stall at the output freezes every stage; in_ready
// is high whenever the output register is empty or being drained. The screen test
// needs only the projected radius quotient qs: |vx*d/z| > qs + 160 holds exactly
// when |vx|*d >= (qs + 161)*z, and likewise with 121 for y. Configuration must be
// written only while the pipeline is empty; the block itself does not enforce it.
`include "sphere_view_cull_assert.svh"

module sphere_view_cull (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [47:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [31:0]       centre_x,
  input  logic signed [31:0]       centre_y,
  input  logic signed [31:0]       centre_z,
  input  logic [14:0]              radius,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     visible
);

  logic signed [31:0] view_x, view_y, view_z;
  logic [47:0]        rot_row0, rot_row1, rot_row2;
  logic [15:0]        proj_distance;

  logic adv;

  logic                             r_valid, r_ok;
  logic [svc_pkg::R_W-1:0]          r_s;
  logic signed [svc_pkg::V_W-1:0]   r_vx, r_vy, r_vz;

  logic                             p_valid, p_live;
  logic [svc_pkg::Z_W-1:0]          p_z;
  logic [svc_pkg::A_W-1:0]          p_ax, p_ay;
  logic [svc_pkg::B_W-1:0]          p_b;

  logic                             d_valid, d_live;
  logic [svc_pkg::B_W-1:0]          d_q;
  logic [svc_pkg::Z_W-1:0]          d_z;
  logic [svc_pkg::A_W-1:0]          d_ax, d_ay;

  logic                             m_valid, m_live;
  logic [svc_pkg::A_W-1:0]          m_ax, m_ay;
  logic [svc_pkg::T_W-1:0]          m_tx, m_ty;

  // whole pipeline advances together; output register parts the two sides
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // configuration; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      view_x        <= '0;
      view_y        <= '0;
      view_z        <= '0;
      rot_row0      <= 48'h0000_0000_1000;
      rot_row1      <= 48'h0000_1000_0000;
      rot_row2      <= 48'h1000_0000_0000;
      proj_distance <= 16'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        svc_pkg::CFG_VIEW_X: view_x        <= cfg_data[31:0];
        svc_pkg::CFG_VIEW_Y: view_y        <= cfg_data[31:0];
        svc_pkg::CFG_VIEW_Z: view_z        <= cfg_data[31:0];
        svc_pkg::CFG_ROW0:   rot_row0      <= cfg_data;
        svc_pkg::CFG_ROW1:   rot_row1      <= cfg_data;
        svc_pkg::CFG_ROW2:   rot_row2      <= cfg_data;
        svc_pkg::CFG_PROJ:   proj_distance <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  svc_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid && in_ready),
    .cx        (centre_x),
    .cy        (centre_y),
    .cz        (centre_z),
    .rad       (radius),
    .view_x    (view_x),
    .view_y    (view_y),
    .view_z    (view_z),
    .rot_row0  (rot_row0),
    .rot_row1  (rot_row1),
    .rot_row2  (rot_row2),
    .out_valid (r_valid),
    .out_ok    (r_ok),
    .out_s     (r_s),
    .vx        (r_vx),
    .vy        (r_vy),
    .vz        (r_vz)
  );

  svc_project u_project (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (r_valid),
    .in_ok     (r_ok),
    .s         (r_s),
    .vx        (r_vx),
    .vy        (r_vy),
    .vz        (r_vz),
    .pd        (proj_distance),
    .out_valid (p_valid),
    .live      (p_live),
    .z         (p_z),
    .ax        (p_ax),
    .ay        (p_ay),
    .b         (p_b)
  );

  svc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (p_valid),
    .in_live   (p_live),
    .num       (p_b),
    .den       (p_z),
    .in_ax     (p_ax),
    .in_ay     (p_ay),
    .out_valid (d_valid),
    .out_live  (d_live),
    .quo       (d_q),
    .out_z     (d_z),
    .out_ax    (d_ax),
    .out_ay    (d_ay)
  );

  // screen bounds scaled back by z
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      m_valid   <= d_valid;
      out_valid <= m_valid;
    end
    if (adv) begin
      m_live  <= d_live;
      m_ax    <= d_ax;
      m_ay    <= d_ay;
      m_tx    <= (svc_pkg::Q_W'(d_q) + svc_pkg::Q_W'(svc_pkg::SXW + 1)) * d_z;
      m_ty    <= (svc_pkg::Q_W'(d_q) + svc_pkg::Q_W'(svc_pkg::SYW + 1)) * d_z;
      visible <= m_live && (svc_pkg::T_W'(m_ax) < m_tx) && (svc_pkg::T_W'(m_ay) < m_ty);
    end
  end

  `SVC_ASSERT_NOW(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "input taken during stall")
  `SVC_ASSERT_NOW(a_live_divisor, d_valid && d_live, d_z > svc_pkg::Z_W'(svc_pkg::NEAR), "live item with small divisor")
  `SVC_ASSERT_NEXT(a_stall_freezes_mult, m_valid && !adv, m_valid && $stable(m_tx), "multiply stage moved during stall")

endmodule

// File: src/svc_rotate.sv
// Offset, range check and 4.12 matrix rotation: three register stages.
// Depends on svc_pkg.
module svc_rotate (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic signed [31:0]                 cx,
  input  logic signed [31:0]                 cy,
  input  logic signed [31:0]                 cz,
  input  logic [svc_pkg::R_W-1:0]            rad,
  input  logic signed [31:0]                 view_x,
  input  logic signed [31:0]                 view_y,
  input  logic signed [31:0]                 view_z,
  input  logic [47:0]                        rot_row0,
  input  logic [47:0]                        rot_row1,
  input  logic [47:0]                        rot_row2,
  output logic                               out_valid,
  output logic                               out_ok,
  output logic [svc_pkg::R_W-1:0]            out_s,
  output logic signed [svc_pkg::V_W-1:0]     vx,
  output logic signed [svc_pkg::V_W-1:0]     vy,
  output logic signed [svc_pkg::V_W-1:0]     vz
);

  logic signed [32:0] full_d [3];
  logic               in_lim [3];

  logic                            v1, ok1;
  logic [svc_pkg::R_W-1:0]         s1;
  logic signed [svc_pkg::D_W-1:0]  d1 [3];

  logic                            v2, ok2;
  logic [svc_pkg::R_W-1:0]         s2;
  logic signed [svc_pkg::P_W-1:0]  p2 [9];

  logic [47:0]                     rows [3];
  logic signed [svc_pkg::P_W+1:0]  sums [3];

  assign rows[0] = rot_row0;
  assign rows[1] = rot_row1;
  assign rows[2] = rot_row2;

  always_comb begin
    full_d[0] = $signed({cx[31], cx}) - $signed({view_x[31], view_x});
    full_d[1] = $signed({cy[31], cy}) - $signed({view_y[31], view_y});
    full_d[2] = $signed({cz[31], cz}) - $signed({view_z[31], view_z});
    for (int i = 0; i < 3; i++) begin
      in_lim[i] = (full_d[i] >= -svc_pkg::OFFSET_LIMIT) &&
                  (full_d[i] <= svc_pkg::OFFSET_LIMIT);
    end
    for (int r = 0; r < 3; r++) begin
      sums[r] = (svc_pkg::P_W+2)'(p2[3*r]) + (svc_pkg::P_W+2)'(p2[3*r+1]) +
                (svc_pkg::P_W+2)'(p2[3*r+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    if (adv) begin
      ok1 <= in_lim[0] && in_lim[1] && in_lim[2];
      s1  <= rad;
      for (int i = 0; i < 3; i++) begin
        d1[i] <= full_d[i][svc_pkg::D_W-1:0];
      end
      ok2 <= ok1;
      s2  <= s1;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p2[3*r+c] <= $signed(rows[r][16*c +: 16]) * d1[c];
        end
      end
      out_ok <= ok2;
      out_s  <= s2;
      // arithmetic shift gives the floor of the 4.12 product
      vx <= sums[0][svc_pkg::P_W+1:12];
      vy <= sums[1][svc_pkg::P_W+1:12];
      vz <= sums[2][svc_pkg::P_W+1:12];
    end
  end

endmodule

// File: src/svc_project.sv
// Near/far test and projection products: one register stage.
// Depends on svc_pkg.
module svc_project (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic                               in_ok,
  input  logic [svc_pkg::R_W-1:0]            s,
  input  logic signed [svc_pkg::V_W-1:0]     vx,
  input  logic signed [svc_pkg::V_W-1:0]     vy,
  input  logic signed [svc_pkg::V_W-1:0]     vz,
  input  logic [15:0]                        pd,
  output logic                               out_valid,
  output logic                               live,
  output logic [svc_pkg::Z_W-1:0]            z,
  output logic [svc_pkg::A_W-1:0]            ax,
  output logic [svc_pkg::A_W-1:0]            ay,
  output logic [svc_pkg::B_W-1:0]            b
);

  logic signed [svc_pkg::V_W:0] zs, zd;
  logic [svc_pkg::V_W-1:0]      mx, my;
  logic                         near_fail, far_fail;

  always_comb begin
    zs = $signed({vz[svc_pkg::V_W-1], vz}) + $signed({8'd0, s});
    zd = $signed({vz[svc_pkg::V_W-1], vz}) - $signed({8'd0, s});
    near_fail = zs <= svc_pkg::NEAR;
    far_fail  = zd > svc_pkg::FAR_LIMIT;
    mx = vx[svc_pkg::V_W-1] ? svc_pkg::V_W'(-vx) : svc_pkg::V_W'(vx);
    my = vy[svc_pkg::V_W-1] ? svc_pkg::V_W'(-vy) : svc_pkg::V_W'(vy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      live <= in_ok && !near_fail && !far_fail;
      // a live item has 150 < z <= 82534, so 17 bits hold it
      z  <= zs[svc_pkg::Z_W-1:0];
      ax <= mx * pd;
      ay <= my * pd;
      b  <= s * pd;
    end
  end

endmodule

// File: src/svc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Depends on svc_pkg.
module svc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic                          in_live,
  input  logic [svc_pkg::B_W-1:0]       num,
  input  logic [svc_pkg::Z_W-1:0]       den,
  input  logic [svc_pkg::A_W-1:0]       in_ax,
  input  logic [svc_pkg::A_W-1:0]       in_ay,
  output logic                          out_valid,
  output logic                          out_live,
  output logic [svc_pkg::B_W-1:0]       quo,
  output logic [svc_pkg::Z_W-1:0]       out_z,
  output logic [svc_pkg::A_W-1:0]       out_ax,
  output logic [svc_pkg::A_W-1:0]       out_ay
);

  localparam int N = svc_pkg::B_W;

  logic                     sv   [N];
  logic                     sl   [N];
  logic [svc_pkg::Z_W-1:0]  srem [N];
  logic [N-1:0]             snum [N];
  logic [svc_pkg::Z_W-1:0]  sz   [N];
  logic [svc_pkg::A_W-1:0]  sax  [N];
  logic [svc_pkg::A_W-1:0]  say  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                     pv, pl;
    logic [svc_pkg::Z_W-1:0]  prem, pz;
    logic [N-1:0]             pnum;
    logic [svc_pkg::A_W-1:0]  pax, pay;
    logic [svc_pkg::Z_W:0]    sh;
    logic                     ge;

    if (i == 0) begin : g_first
      assign pv = in_valid;
      assign pl = in_live;
      assign prem = '0;
      assign pnum = num;
      assign pz = den;
      assign pax = in_ax;
      assign pay = in_ay;
    end else begin : g_next
      assign pv = sv[i-1];
      assign pl = sl[i-1];
      assign prem = srem[i-1];
      assign pnum = snum[i-1];
      assign pz = sz[i-1];
      assign pax = sax[i-1];
      assign pay = say[i-1];
    end

    assign sh = {prem, pnum[N-1]};
    assign ge = sh >= {1'b0, pz};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i] <= 1'b0;
      end else if (adv) begin
        sv[i] <= pv;
      end
      if (adv) begin
        sl[i]   <= pl;
        srem[i] <= ge ? svc_pkg::Z_W'(sh - {1'b0, pz}) : sh[svc_pkg::Z_W-1:0];
        snum[i] <= {pnum[N-2:0], ge};
        sz[i]   <= pz;
        sax[i]  <= pax;
        say[i]  <= pay;
      end
    end
  end

  assign out_valid = sv[N-1];
  assign out_live  = sl[N-1];
  assign quo       = snum[N-1];
  assign out_z     = sz[N-1];
  assign out_ax    = sax[N-1];
  assign out_ay    = say[N-1];

endmodule
